[sv/modexp_pkg.sv]
`timescale 1ns / 1ps
package modexp_pkg;
  localparam int DefaultWidth = 64;
  localparam int CfgIdxW = 64;

  localparam logic [CfgIdxW-1:0] RegModulus  = 64'd0;
  localparam logic [CfgIdxW-1:0] RegExponent = 64'd1;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_SQR_START,
    ST_SQR_WAIT,
    ST_DONE
  } state_t;
endpackage

[sv/modexp_mulmod.sv]
`timescale 1ns / 1ps
module modexp_mulmod #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] n,
  output logic             done,
  output logic [WIDTH-1:0] prod
);
  localparam int CntW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] y_r, y_nxt;
  logic [WIDTH-1:0] x_r;
  logic [WIDTH-1:0] n_r;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH-1:0] dbl, sum;

  // Modular add of two values below the modulus, without overflow.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] gap;
    gap = m - b;
    if (a >= gap) return a - gap;
    return a + b;
  endfunction

  // One multiplier bit per cycle, most significant first.
  always_comb begin
    dbl = add_mod(acc_r, acc_r, n_r);
    sum = y_r[WIDTH-1] ? add_mod(dbl, x_r, n_r) : dbl;
    acc_nxt = acc_r;
    y_nxt = y_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      y_nxt = y;
      cnt_nxt = CntW'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = sum;
      y_nxt = {y_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    y_r <= y_nxt;
    if (start) begin
      x_r <= x;
      n_r <= n;
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

[sv/modexp_reduce.sv]
`timescale 1ns / 1ps
module modexp_reduce #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] n,
  output logic             done,
  output logic [WIDTH-1:0] rem
);
  localparam int CntW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] n_r;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH:0]   trial;

  // Restoring remainder, one dividend bit per cycle.
  always_comb begin
    trial = {rem_r, a_r[WIDTH-1]};
    rem_nxt = rem_r;
    a_nxt = a_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      a_nxt = a;
      cnt_nxt = CntW'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, n_r}) rem_nxt = WIDTH'(trial - {1'b0, n_r});
      else rem_nxt = trial[WIDTH-1:0];
      a_nxt = {a_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    a_r <= a_nxt;
    if (start) n_r <= n;
  end

  assign done = done_r;
  assign rem = rem_r;
endmodule

[sv/modular_exponentiation_top.sv]
`timescale 1ns / 1ps
// Right-to-left square-and-multiply modular exponentiation. Write the modulus
// (index 0) and exponent (index 1) while idle; each message request then yields
// one result, message to the exponent mod modulus. One item at a time: the
// base is first reduced, then for each of the WIDTH exponent bits the sequencer
// makes a multiply decision and a squaring decision. A multiplication for each
// set bit and a squaring for every bit but the last run on a shared bit-serial
// shift-add multiplier. A result that waits on out_stall is held. A modulus
// of zero or one gives zero, offered in the cycle after acceptance.
module modular_exponentiation_top #(
  parameter int WIDTH = modexp_pkg::DefaultWidth
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [modexp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [WIDTH-1:0]                 cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [WIDTH-1:0]                 in_message,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [WIDTH-1:0]                 out_power_result
);
  import modexp_pkg::*;
  localparam int BitW = $clog2(WIDTH);

  state_t           state_r, state_nxt;
  logic [WIDTH-1:0] modulus_r, exponent_r;
  logic [WIDTH-1:0] base_r, base_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] exp_r, exp_nxt;
  logic [BitW-1:0]  bit_r, bit_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] res_r, res_nxt;
  logic             red_start, red_done;
  logic [WIDTH-1:0] red_rem;
  logic             mul_start, mul_done;
  logic [WIDTH-1:0] mul_x, mul_y, mul_prod;
  logic             accept;
  logic             small_mod;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= WIDTH'(2);
      exponent_r <= WIDTH'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        RegModulus:  modulus_r <= cfg_data;
        RegExponent: exponent_r <= cfg_data;
        default: ;
      endcase
    end
  end

  modexp_reduce #(.WIDTH(WIDTH)) u_reduce (
    .clk(clk), .rst_n(rst_n), .start(red_start), .a(in_message),
    .n(modulus_r), .done(red_done), .rem(red_rem)
  );

  modexp_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .x(mul_x), .y(mul_y),
    .n(modulus_r), .done(mul_done), .prod(mul_prod)
  );

  assign small_mod = (modulus_r[WIDTH-1:1] == '0);
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign accept = in_valid && !in_stall;
  assign red_start = accept && !small_mod;
  assign mul_x = (state_r == ST_MUL_START) ? acc_r : base_r;
  assign mul_y = base_r;

  // Sequencer over the exponent bits.
  always_comb begin
    state_nxt = state_r;
    base_nxt = base_r;
    acc_nxt = acc_r;
    exp_nxt = exp_r;
    bit_nxt = bit_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          exp_nxt = exponent_r;
          bit_nxt = '0;
          acc_nxt = WIDTH'(1);
          if (small_mod) begin
            res_nxt = '0;
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (red_done) begin
          base_nxt = red_rem;
          state_nxt = ST_MUL_START;
        end
      end
      ST_MUL_START: begin
        if (exp_r[0]) begin
          mul_start = 1'b1;
          state_nxt = ST_MUL_WAIT;
        end else begin
          state_nxt = ST_SQR_START;
        end
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          acc_nxt = mul_prod;
          state_nxt = ST_SQR_START;
        end
      end
      ST_SQR_START: begin
        if (bit_r == BitW'(WIDTH - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          mul_start = 1'b1;
          state_nxt = ST_SQR_WAIT;
        end
      end
      ST_SQR_WAIT: begin
        if (mul_done) begin
          base_nxt = mul_prod;
          exp_nxt = exp_r >> 1;
          bit_nxt = bit_r + 1'b1;
          state_nxt = ST_MUL_START;
        end
      end
      ST_DONE: begin
        res_nxt = acc_r;
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    base_r <= base_nxt;
    acc_r <= acc_nxt;
    exp_r <= exp_nxt;
    bit_r <= bit_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_power_result = res_r;
endmodule

[sv/modexp_checker.sv]
`timescale 1ns / 1ps
module modexp_checker #(
  parameter int WIDTH = 64
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [WIDTH-1:0] out_power_result
);
  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_power_result))
    else $error("stalled result changed");

  // No request is taken while a result waits.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while result pending");

  // A new result only follows an accepted request.
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall) || $past(in_valid))
    else $error("result without request");

  // After reset the block is ready and empty.
  a_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result after reset");
endmodule

bind modular_exponentiation_top modexp_checker #(.WIDTH(WIDTH)) u_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_power_result(out_power_result)
);
